FILE: hdl/gts_pkg.sv
// ----------------------------------------------------------------------------
// gts_pkg: shared types and constants
// Widths, codes and helpers for the two-deme stochastic step engine.
// ----------------------------------------------------------------------------
package gts_pkg;

   localparam int CFG_W   = 36;   // Q4.32 rate registers
   localparam int CAP_W   = 16;   // carrying capacities
   localparam int RATE_W  = 40;   // one reaction rate, Q24.16
   localparam int SUM_W   = 44;   // exact sum of twelve rates
   localparam int TIME_W  = 48;   // simulated time, Q32.16
   localparam int FRAC_W  = 32;
   localparam int MA_W    = 36;   // multiplier operand a
   localparam int MB_W    = 32;   // multiplier operand b
   localparam int PROD_W  = MA_W + MB_W;
   localparam int LOG_W   = 38;   // ln value, Q6.32
   localparam int DIV_RW  = SUM_W;
   localparam int DIV_QW  = LOG_W;
   localparam int DIV_CW  = 6;

   localparam logic [MB_W-1:0]   LN2_Q32  = 32'd2977044472;
   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [DIV_CW-1:0] LOGI_ITERS = DIV_CW'(FRAC_W);
   localparam logic [DIV_CW-1:0] TIME_ITERS = DIV_CW'(DIV_QW);

   typedef enum logic [0:0] {
      FUNC_START = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_STEP    = 2'd0,
      ST_START   = 2'd1,
      ST_EXTINCT = 2'd2,
      ST_ZERO    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_WILD_FIT  = 3'd0,
      CSR_WILD_DTH  = 3'd1,
      CSR_MUT_FIT   = 3'd2,
      CSR_MUT_DTH   = 3'd3,
      CSR_S2L_RATE  = 3'd4,
      CSR_L2S_RATE  = 3'd5,
      CSR_LARGE_CAP = 3'd6,
      CSR_SMALL_CAP = 3'd7
   } csr_type;

   typedef enum logic [3:0] {
      RX_WL_BIRTH = 4'd0,
      RX_WL_DEATH = 4'd1,
      RX_WS_BIRTH = 4'd2,
      RX_WS_DEATH = 4'd3,
      RX_ML_BIRTH = 4'd4,
      RX_ML_DEATH = 4'd5,
      RX_MS_BIRTH = 4'd6,
      RX_MS_DEATH = 4'd7,
      RX_WILD_L2S = 4'd8,
      RX_WILD_S2L = 4'd9,
      RX_MUT_L2S  = 4'd10,
      RX_MUT_S2L  = 4'd11
   } reaction_type;

   // launch request for the serial divider
   typedef struct packed {
      logic              start;
      logic [DIV_RW-1:0] rem0;
      logic [DIV_QW-1:0] dvd0;
      logic [DIV_RW-1:0] divisor;
      logic [DIV_CW-1:0] iters;
   } div_req_type;

   function automatic logic [RATE_W-1:0] cap_rate(input logic [PROD_W-17:0] v);
      if (v > (PROD_W-16)'(RATE_MAX)) return RATE_MAX;
      return RATE_W'(v);
   endfunction

endpackage

FILE: hdl/gillespie_two_deme_step.sv
// ----------------------------------------------------------------------------
// gillespie_two_deme_step: one direct-method reaction step, two demes
// Start words load counts; step words pick and apply one reaction and
// advance the simulated time by ln(1/u)/total.
// ----------------------------------------------------------------------------
// Start and extinct words skip all arithmetic; a full step's length is set
// by the serial divider (one bit a cycle, up to three divisions), 32 log2
// squarings and the rate products on the one shared multiplier; a zero u_time
// or a zero total skips the log and the time divide.
// Throughput: one word at a time; req_stall is high until the result is
// registered. Reset (synchronous) zeroes counts and time, loads defaults.
module gillespie_two_deme_step
   import gts_pkg::*;
#(
   parameter int COUNT_BITS    = 16,
   parameter int NUM_REACTIONS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [15:0]         req_init_wild_large,
   input  logic [15:0]         req_init_mutant_small,
   input  logic [31:0]         req_u_select,
   input  logic [31:0]         req_u_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_reaction,
   output logic [15:0]         rsp_wild_large,
   output logic [15:0]         rsp_wild_small,
   output logic [15:0]         rsp_mutant_large,
   output logic [15:0]         rsp_mutant_small,
   output logic [TIME_W-1:0]   rsp_elapsed,
   output logic [RATE_W-1:0]   rsp_total_rate,
   output logic [1:0]          rsp_status,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_data
);

   localparam int CB = COUNT_BITS;
   localparam int IW = $clog2(NUM_REACTIONS);
   localparam int WB = (CB > 16) ? CB : 16;
   localparam int NW = ((CB + 1) > CAP_W) ? (CB + 1) : CAP_W;
   localparam logic [CB-1:0] CMAX = {CB{1'b1}};

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_FL    = 11'b00000000010,
      S_FS    = 11'b00000000100,
      S_RATE  = 11'b00000001000,
      S_TGT   = 11'b00000010000,
      S_PICK  = 11'b00000100000,
      S_NORM  = 11'b00001000000,
      S_SQR   = 11'b00010000000,
      S_SCALE = 11'b00100000000,
      S_TDIV  = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   function automatic logic [CB-1:0] inc_sat(input logic [CB-1:0] v);
      return (v == CMAX) ? v : v + CB'(1);
   endfunction

   function automatic logic [CB-1:0] dec_sat(input logic [CB-1:0] v);
      return (v == '0) ? v : v - CB'(1);
   endfunction

   function automatic logic [CB-1:0] sat_init(input logic [15:0] v);
      logic [WB-1:0] e;
      e = WB'(v);
      if (e > WB'(CMAX)) return CMAX;
      return CB'(e);
   endfunction

   // sequencer and configuration
   state_type          state_ff, state_in;
   logic               ph_ff, ph_in;
   logic               sub_ff, sub_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [CFG_W-1:0]   wfit_ff, wfit_in, wdth_ff, wdth_in;
   logic [CFG_W-1:0]   mfit_ff, mfit_in, mdth_ff, mdth_in;
   logic [CFG_W-1:0]   s2l_ff, s2l_in, l2s_ff, l2s_in;
   logic [CAP_W-1:0]   lcap_ff, lcap_in, scap_ff, scap_in;
   // population state
   logic [CB-1:0]      wl_ff, wl_in, ws_ff, ws_in, ml_ff, ml_in, ms_ff, ms_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   // working registers
   logic [31:0]        usel_ff, usel_in, utime_ff, utime_in;
   logic [FRAC_W-1:0]  fl_ff, fl_in, fs_ff, fs_in;
   logic [MA_W-1:0]    bmid_ff, bmid_in;
   logic [RATE_W-1:0]  rates_ff [NUM_REACTIONS];
   logic [RATE_W-1:0]  rate_in;
   logic               rate_we;
   logic [SUM_W-1:0]   sum_ff, sum_in, tgt_ff, tgt_in, run_ff, run_in;
   logic [31:0]        x_ff, x_in;
   logic [4:0]         shf_ff, shf_in, sq_ff, sq_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [LOG_W-1:0]   lacc_ff, lacc_in;
   reaction_type       res_rx_ff, res_rx_in;
   logic [RATE_W-1:0]  res_tot_ff, res_tot_in;
   status_type         res_st_ff, res_st_in;
   // output stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_rx_ff, rsp_rx_in;
   logic [15:0]        rsp_wl_ff, rsp_wl_in, rsp_ws_ff, rsp_ws_in;
   logic [15:0]        rsp_ml_ff, rsp_ml_in, rsp_ms_ff, rsp_ms_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;
   logic [RATE_W-1:0]  rsp_tot_ff, rsp_tot_in;
   logic [1:0]         rsp_st_ff, rsp_st_in;

   // datapath wires
   logic [MA_W-1:0]    mul_a;
   logic [MB_W-1:0]    mul_b;
   logic [PROD_W-1:0]  prod;
   div_req_type        div_req;
   logic               div_done;
   logic [DIV_QW-1:0]  quot;

   reaction_type       rx;
   logic               is_birth;
   logic [CFG_W-1:0]   coef;
   logic [FRAC_W-1:0]  fsel;
   logic [CB-1:0]      cnt;
   logic [NW-1:0]      lg_n, lg_k;
   logic [SUM_W-1:0]   sum_nxt, run_nxt;
   logic [32:0]        sq_y;
   logic [LOG_W-1:0]   l2;
   logic [RATE_W-1:0]  rate_cur;
   logic [TIME_W-1:0]  dt;
   logic               accept;

   gts_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   gts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (quot)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // per-reaction operand selection
   always_comb begin
      rx       = reaction_type'(4'(idx_ff));
      is_birth = 1'b0;
      coef     = wdth_ff;
      fsel     = fl_ff;
      cnt      = wl_ff;
      unique case (rx)
         RX_WL_BIRTH: begin is_birth = 1'b1; coef = wfit_ff; end
         RX_WL_DEATH: coef = wdth_ff;
         RX_WS_BIRTH: begin is_birth = 1'b1; coef = wfit_ff; fsel = fs_ff; cnt = ws_ff; end
         RX_WS_DEATH: begin coef = wdth_ff; cnt = ws_ff; end
         RX_ML_BIRTH: begin is_birth = 1'b1; coef = mfit_ff; cnt = ml_ff; end
         RX_ML_DEATH: begin coef = mdth_ff; cnt = ml_ff; end
         RX_MS_BIRTH: begin is_birth = 1'b1; coef = mfit_ff; fsel = fs_ff; cnt = ms_ff; end
         RX_MS_DEATH: begin coef = mdth_ff; cnt = ms_ff; end
         RX_WILD_L2S: coef = l2s_ff;
         RX_WILD_S2L: begin coef = s2l_ff; cnt = ws_ff; end
         RX_MUT_L2S:  begin coef = l2s_ff; cnt = ml_ff; end
         RX_MUT_S2L:  begin coef = s2l_ff; cnt = ms_ff; end
         default: ;
      endcase
   end

   // deme load and capacity for the logistic factor
   always_comb begin
      if (state_ff == S_FS) begin
         lg_n = NW'(ws_ff) + NW'(ms_ff);
         lg_k = NW'(scap_ff);
      end else begin
         lg_n = NW'(wl_ff) + NW'(ml_ff);
         lg_k = NW'(lcap_ff);
      end
   end

   assign rate_cur = cap_rate(prod[PROD_W-1:16]);
   assign sum_nxt  = sum_ff + SUM_W'(rate_cur);
   assign run_nxt  = run_ff + SUM_W'(rates_ff[idx_ff]);
   assign sq_y     = prod[63:31];
   assign l2       = ((LOG_W'(shf_ff) + LOG_W'(1)) << 32) - LOG_W'(frac_ff);
   assign dt       = TIME_W'(quot);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_RATE: begin
            if (is_birth && !sub_ff) begin
               mul_a = coef;
               mul_b = fsel;
            end else if (is_birth) begin
               mul_a = bmid_ff;
               mul_b = MB_W'(cnt);
            end else begin
               mul_a = coef;
               mul_b = MB_W'(cnt);
            end
         end
         S_TGT: begin
            if (!sub_ff) begin
               mul_a = MA_W'(usel_ff);
               mul_b = sum_ff[31:0];
            end else begin
               mul_a = MA_W'(sum_ff[SUM_W-1:32]);
               mul_b = usel_ff;
            end
         end
         S_SQR: begin
            mul_a = MA_W'(x_ff);
            mul_b = x_ff;
         end
         S_SCALE: begin
            mul_a = sub_ff ? MA_W'(l2[LOG_W-1:32]) : MA_W'(l2[31:0]);
            mul_b = LN2_Q32;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ph_in      = ph_ff;
      sub_in     = sub_ff;
      idx_in     = idx_ff;
      wfit_in    = wfit_ff;
      wdth_in    = wdth_ff;
      mfit_in    = mfit_ff;
      mdth_in    = mdth_ff;
      s2l_in     = s2l_ff;
      l2s_in     = l2s_ff;
      lcap_in    = lcap_ff;
      scap_in    = scap_ff;
      wl_in      = wl_ff;
      ws_in      = ws_ff;
      ml_in      = ml_ff;
      ms_in      = ms_ff;
      time_in    = time_ff;
      usel_in    = usel_ff;
      utime_in   = utime_ff;
      fl_in      = fl_ff;
      fs_in      = fs_ff;
      bmid_in    = bmid_ff;
      rate_in    = rate_cur;
      rate_we    = 1'b0;
      sum_in     = sum_ff;
      tgt_in     = tgt_ff;
      run_in     = run_ff;
      x_in       = x_ff;
      shf_in     = shf_ff;
      sq_in      = sq_ff;
      frac_in    = frac_ff;
      lacc_in    = lacc_ff;
      res_rx_in  = res_rx_ff;
      res_tot_in = res_tot_ff;
      res_st_in  = res_st_ff;
      div_req    = '0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rx_in    = rsp_rx_ff;
      rsp_wl_in    = rsp_wl_ff;
      rsp_ws_in    = rsp_ws_ff;
      rsp_ml_in    = rsp_ml_ff;
      rsp_ms_in    = rsp_ms_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_st_in    = rsp_st_ff;

      // configuration writes
      if (csr_write) begin
         unique case (csr_type'(csr_index))
            CSR_WILD_FIT:  wfit_in = csr_data;
            CSR_WILD_DTH:  wdth_in = csr_data;
            CSR_MUT_FIT:   mfit_in = csr_data;
            CSR_MUT_DTH:   mdth_in = csr_data;
            CSR_S2L_RATE:  s2l_in  = csr_data;
            CSR_L2S_RATE:  l2s_in  = csr_data;
            CSR_LARGE_CAP: lcap_in = csr_data[CAP_W-1:0];
            CSR_SMALL_CAP: scap_in = csr_data[CAP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_rx_in  = RX_WL_BIRTH;
               res_tot_in = '0;
               if (func_type'(req_func) == FUNC_START) begin
                  wl_in     = sat_init(req_init_wild_large);
                  ws_in     = '0;
                  ml_in     = '0;
                  ms_in     = sat_init(req_init_mutant_small);
                  time_in   = '0;
                  res_st_in = ST_START;
                  state_in  = S_DONE;
               end else if ((wl_ff == '0 && ws_ff == '0) ||
                            (ml_ff == '0 && ms_ff == '0)) begin
                  res_st_in = ST_EXTINCT;
                  state_in  = S_DONE;
               end else begin
                  usel_in  = req_u_select;
                  utime_in = req_u_time;
                  sum_in   = '0;
                  sub_in   = 1'b0;
                  state_in = S_FL;
               end
            end
         end
         // logistic factors, large deme then small deme
         S_FL, S_FS: begin
            if (!sub_ff) begin
               if (lg_k == '0 || lg_n >= lg_k) begin
                  if (state_ff == S_FL) begin
                     fl_in    = '0;
                     state_in = S_FS;
                  end else begin
                     fs_in    = '0;
                     state_in = S_RATE;
                     idx_in   = '0;
                     ph_in    = 1'b0;
                  end
               end else begin
                  div_req.start   = 1'b1;
                  div_req.rem0    = DIV_RW'(lg_k - lg_n);
                  div_req.dvd0    = '0;
                  div_req.divisor = DIV_RW'(lg_k);
                  div_req.iters   = LOGI_ITERS;
                  sub_in          = 1'b1;
               end
            end else if (div_done) begin
               sub_in = 1'b0;
               if (state_ff == S_FL) begin
                  fl_in    = quot[FRAC_W-1:0];
                  state_in = S_FS;
               end else begin
                  fs_in    = quot[FRAC_W-1:0];
                  state_in = S_RATE;
                  idx_in   = '0;
                  ph_in    = 1'b0;
               end
            end
         end
         // twelve rates, births take two products
         S_RATE: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (is_birth && !sub_ff) begin
                  bmid_in = prod[PROD_W-1:32];
                  sub_in  = 1'b1;
               end else begin
                  rate_we = 1'b1;
                  sum_in  = sum_nxt;
                  sub_in  = 1'b0;
                  if (idx_ff == IW'(NUM_REACTIONS - 1)) begin
                     if (sum_nxt == '0) begin
                        res_st_in = ST_ZERO;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_TGT;
                     end
                  end else begin
                     idx_in = idx_ff + IW'(1);
                  end
               end
            end
         end
         // target = u_select * sum >> 32, in two partial products
         S_TGT: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (!sub_ff) begin
                  tgt_in = SUM_W'(prod[PROD_W-1:32]);
                  sub_in = 1'b1;
               end else begin
                  tgt_in   = tgt_ff + prod[SUM_W-1:0];
                  sub_in   = 1'b0;
                  idx_in   = '0;
                  run_in   = '0;
                  state_in = S_PICK;
               end
            end
         end
         // scan running sum, apply the chosen reaction
         S_PICK: begin
            if (rates_ff[idx_ff] != '0 && run_nxt >= tgt_ff) begin
               res_rx_in  = rx;
               res_tot_in = (sum_ff > SUM_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(sum_ff);
               res_st_in  = ST_STEP;
               unique case (rx)
                  RX_WL_BIRTH: wl_in = inc_sat(wl_ff);
                  RX_WL_DEATH: wl_in = dec_sat(wl_ff);
                  RX_WS_BIRTH: ws_in = inc_sat(ws_ff);
                  RX_WS_DEATH: ws_in = dec_sat(ws_ff);
                  RX_ML_BIRTH: ml_in = inc_sat(ml_ff);
                  RX_ML_DEATH: ml_in = dec_sat(ml_ff);
                  RX_MS_BIRTH: ms_in = inc_sat(ms_ff);
                  RX_MS_DEATH: ms_in = dec_sat(ms_ff);
                  RX_WILD_L2S: begin wl_in = dec_sat(wl_ff); ws_in = inc_sat(ws_ff); end
                  RX_WILD_S2L: begin wl_in = inc_sat(wl_ff); ws_in = dec_sat(ws_ff); end
                  RX_MUT_L2S:  begin ml_in = dec_sat(ml_ff); ms_in = inc_sat(ms_ff); end
                  default:     begin ml_in = inc_sat(ml_ff); ms_in = dec_sat(ms_ff); end
               endcase
               if (utime_ff == '0) begin
                  time_in  = TIME_MAX;
                  state_in = S_DONE;
               end else begin
                  x_in     = utime_ff;
                  shf_in   = '0;
                  state_in = S_NORM;
               end
            end else begin
               run_in = run_nxt;
               idx_in = idx_ff + IW'(1);
            end
         end
         // normalize u_time, one bit a cycle
         S_NORM: begin
            if (x_ff[31]) begin
               frac_in  = '0;
               sq_in    = '0;
               ph_in    = 1'b0;
               state_in = S_SQR;
            end else begin
               x_in   = {x_ff[30:0], 1'b0};
               shf_in = shf_ff + 5'd1;
            end
         end
         // log2 fraction bits by repeated squaring
         S_SQR: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               frac_in = {frac_ff[FRAC_W-2:0], sq_y[32]};
               x_in    = sq_y[32] ? sq_y[32:1] : sq_y[31:0];
               if (sq_ff == 5'd31) begin
                  sub_in   = 1'b0;
                  state_in = S_SCALE;
               end else begin
                  sq_in = sq_ff + 5'd1;
               end
            end
         end
         // ln = log2 * ln2, in two partial products
         S_SCALE: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (!sub_ff) begin
                  lacc_in = LOG_W'(prod[63:32]);
                  sub_in  = 1'b1;
               end else begin
                  lacc_in  = lacc_ff + prod[LOG_W-1:0];
                  sub_in   = 1'b0;
                  state_in = S_TDIV;
               end
            end
         end
         // dt = ln / sum, saturating time add
         S_TDIV: begin
            if (!sub_ff) begin
               div_req.start   = 1'b1;
               div_req.rem0    = '0;
               div_req.dvd0    = lacc_ff;
               div_req.divisor = sum_ff;
               div_req.iters   = TIME_ITERS;
               sub_in          = 1'b1;
            end else if (div_done) begin
               sub_in   = 1'b0;
               time_in  = (dt >= TIME_MAX - time_ff) ? TIME_MAX : time_ff + dt;
               state_in = S_DONE;
            end
         end
         // hand the word to the output stage once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rx_in    = res_rx_ff;
               rsp_wl_in    = 16'(wl_ff);
               rsp_ws_in    = 16'(ws_ff);
               rsp_ml_in    = 16'(ml_ff);
               rsp_ms_in    = 16'(ms_ff);
               rsp_time_in  = time_ff;
               rsp_tot_in   = res_tot_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wfit_ff      <= 36'd4294967296;
         wdth_ff      <= 36'd429496730;
         mfit_ff      <= 36'd4337916969;
         mdth_ff      <= 36'd429496730;
         s2l_ff       <= 36'd34360;
         l2s_ff       <= 36'd4295;
         lcap_ff      <= 16'd400;
         scap_ff      <= 16'd100;
         wl_ff        <= '0;
         ws_ff        <= '0;
         ml_ff        <= '0;
         ms_ff        <= '0;
         time_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wfit_ff      <= wfit_in;
         wdth_ff      <= wdth_in;
         mfit_ff      <= mfit_in;
         mdth_ff      <= mdth_in;
         s2l_ff       <= s2l_in;
         l2s_ff       <= l2s_in;
         lcap_ff      <= lcap_in;
         scap_ff      <= scap_in;
         wl_ff        <= wl_in;
         ws_ff        <= ws_in;
         ml_ff        <= ml_in;
         ms_ff        <= ms_in;
         time_ff      <= time_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      ph_ff       <= ph_in;
      sub_ff      <= sub_in;
      idx_ff      <= idx_in;
      usel_ff     <= usel_in;
      utime_ff    <= utime_in;
      fl_ff       <= fl_in;
      fs_ff       <= fs_in;
      bmid_ff     <= bmid_in;
      sum_ff      <= sum_in;
      tgt_ff      <= tgt_in;
      run_ff      <= run_in;
      x_ff        <= x_in;
      shf_ff      <= shf_in;
      sq_ff       <= sq_in;
      frac_ff     <= frac_in;
      lacc_ff     <= lacc_in;
      res_rx_ff   <= res_rx_in;
      res_tot_ff  <= res_tot_in;
      res_st_ff   <= res_st_in;
      rsp_rx_ff   <= rsp_rx_in;
      rsp_wl_ff   <= rsp_wl_in;
      rsp_ws_ff   <= rsp_ws_in;
      rsp_ml_ff   <= rsp_ml_in;
      rsp_ms_ff   <= rsp_ms_in;
      rsp_time_ff <= rsp_time_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_st_ff   <= rsp_st_in;
      if (rate_we) begin
         rates_ff[idx_ff] <= rate_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reaction     = rsp_rx_ff;
   assign rsp_wild_large   = rsp_wl_ff;
   assign rsp_wild_small   = rsp_ws_ff;
   assign rsp_mutant_large = rsp_ml_ff;
   assign rsp_mutant_small = rsp_ms_ff;
   assign rsp_elapsed      = rsp_time_ff;
   assign rsp_total_rate   = rsp_tot_ff;
   assign rsp_status       = rsp_st_ff;

   // a stepped word always carries a nonzero total
   a_step_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_st_ff == ST_STEP) |-> rsp_tot_ff != '0)
      else $error("stepped word with zero total rate");

   // words that did not step report reaction zero and total zero
   a_nostep_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_st_ff != ST_STEP) |-> (rsp_rx_ff == '0 && rsp_tot_ff == '0))
      else $error("non-step word with reaction or total set");

   // a start word shows cleared time
   a_start_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_st_ff == ST_START) |-> rsp_time_ff == '0)
      else $error("start word with nonzero time");

   // the reaction index stays within the reaction list
   a_rx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rx_ff < 4'(NUM_REACTIONS))
      else $error("reaction index out of range");

   // the divider is only launched from its sequencer states
   a_div_launch: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == S_FL || state_ff == S_FS || state_ff == S_TDIV))
      else $error("divider launched outside a divide state");

endmodule

FILE: hdl/gts_mul.sv
// ----------------------------------------------------------------------------
// gts_mul: shared multiplier
// One 36x32 unsigned product, registered at its output.
// ----------------------------------------------------------------------------
module gts_mul
   import gts_pkg::*;
(
   input  logic              clock,
   input  logic [MA_W-1:0]   op_a,
   input  logic [MB_W-1:0]   op_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: hdl/gts_div.sv
// ----------------------------------------------------------------------------
// gts_div: serial restoring divider
// One quotient bit a cycle; remainder preload allows fractional quotients.
// ----------------------------------------------------------------------------
module gts_div
   import gts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       req,
   output logic              done,
   output logic [DIV_QW-1:0] quot
);

   logic [DIV_RW-1:0] rem_ff, rem_in;
   logic [DIV_QW-1:0] q_ff, q_in;
   logic [DIV_RW-1:0] div_ff, div_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_RW:0]   trial;
   logic [DIV_RW:0]   diff;
   logic              ge;

   // shift one dividend bit into the partial remainder and try to subtract
   assign trial = {rem_ff, q_ff[DIV_QW-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = req.rem0;
         q_in   = req.dvd0;
         div_in = req.divisor;
         cnt_in = req.iters;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
         q_in   = {q_ff[DIV_QW-2:0], ge};
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == DIV_CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
